// ===== rtl/extended_euclid_modular_inverse_core_defines.svh =====
// ----------------------------------------------------------------------------
// Extended Euclid modular inverse core - assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef EXTENDED_EUCLID_MODULAR_INVERSE_CORE_DEFINES_SVH
`define EXTENDED_EUCLID_MODULAR_INVERSE_CORE_DEFINES_SVH

// same-cycle implication, masked during reset
`define EEMI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked during reset
`define EEMI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, active through reset
`define EEMI_ASSERT_NEXT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/eemi_pkg.sv =====
// ----------------------------------------------------------------------------
// Extended Euclid modular inverse - package
// Widths, coefficient type, sequencer states and divider interface structs.
// ----------------------------------------------------------------------------
package eemi_pkg;

  localparam int W     = 32;
  localparam int IN_W  = ((2 * W + 7) / 8) * 8;
  localparam int OUT_W = ((4 * W + 2 + 7) / 8) * 8;
  localparam int CNT_W = $clog2(W + 2);

  typedef logic [W-1:0]        word_t;
  typedef logic [W:0]          dword_t;
  typedef logic signed [W:0]   coef_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_RDIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic   start;
    dword_t dividend;
    word_t  divisor;
    coef_t  mul_x;
    coef_t  mul_y;
  } div_req_t;

  typedef struct packed {
    logic  done;
    word_t rem;
    coef_t prod_x;
    coef_t prod_y;
  } div_rsp_t;

endpackage

// ===== rtl/eemi_divider.sv =====
// ----------------------------------------------------------------------------
// Extended Euclid modular inverse - shared divider
// Restoring divider, one quotient bit per cycle. Quotient bits also drive
// two Horner accumulators that form quotient times each coefficient.
// ----------------------------------------------------------------------------
module eemi_divider (
  input  logic                clk,
  input  logic                rst,
  input  eemi_pkg::div_req_t  req,
  output eemi_pkg::div_rsp_t  rsp
);
  import eemi_pkg::*;

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  word_t            rem;
  dword_t           quo;
  word_t            divisor;
  coef_t            mul_x;
  coef_t            mul_y;
  coef_t            acc_x;
  coef_t            acc_y;

  dword_t trial;
  logic   ge;
  word_t  rem_next;

  assign trial    = {rem, quo[W]};
  assign ge       = trial >= {1'b0, divisor};
  assign rem_next = ge ? W'(trial - {1'b0, divisor}) : trial[W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(W)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= '0;
      quo     <= req.dividend;
      divisor <= req.divisor;
      mul_x   <= req.mul_x;
      mul_y   <= req.mul_y;
      acc_x   <= '0;
      acc_y   <= '0;
    end else if (busy) begin
      rem   <= rem_next;
      quo   <= {quo[W-1:0], ge};
      acc_x <= (acc_x <<< 1) + (ge ? mul_x : coef_t'(0));
      acc_y <= (acc_y <<< 1) + (ge ? mul_y : coef_t'(0));
    end
  end

  assign rsp.done   = done;
  assign rsp.rem    = rem;
  assign rsp.prod_x = acc_x;
  assign rsp.prod_y = acc_y;

endmodule

// ===== rtl/extended_euclid_modular_inverse_core.sv =====
// Throughput: one transaction at a time; a new input is accepted only after the
//   previous result is loaded into the output register, so output stalls also
//   hold off input. The shared bit-serial divider (one quotient bit per cycle)
//   sets the pace.
// Reset: synchronous, active high; clears sequencer and output valid.
// ----------------------------------------------------------------------------
// Extended Euclid modular inverse core - top level
// Sequencer around a shared divider: gcd, Bezout coefficients and inverse.
// ----------------------------------------------------------------------------
module extended_euclid_modular_inverse_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [eemi_pkg::IN_W-1:0] s_tdata,   // value, modulus
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [eemi_pkg::OUT_W-1:0] m_tdata   // gcd, coef_value, coef_modulus, inverse
);
  import eemi_pkg::*;

  state_t   state;
  state_t   state_next;
  word_t    a;
  word_t    b;
  word_t    m;
  coef_t    xp;
  coef_t    xc;
  coef_t    yp;
  coef_t    yc;
  word_t    inv;
  div_req_t req;
  div_rsp_t rsp;
  logic     out_load;
  dword_t   abs_xp;

  eemi_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  assign abs_xp = xp[W] ? dword_t'(-xp) : dword_t'(xp);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (b != '0) state_next = ST_DIV;
        else if (m != '0) state_next = ST_RDIV;
        else state_next = ST_FINISH;
      end
      ST_DIV: begin
        if (rsp.done) state_next = ST_CHECK;
      end
      ST_RDIV: begin
        if (rsp.done) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready     = (state == ST_IDLE);
    out_load     = (state == ST_FINISH) && (!m_tvalid || m_tready);
    req.start    = (state == ST_CHECK) && ((b != '0) || (m != '0));
    req.dividend = (b != '0) ? {1'b0, a} : abs_xp;
    req.divisor  = (b != '0) ? b : m;
    req.mul_x    = xc;
    req.mul_y    = yc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          a  <= s_tdata[W-1:0];
          b  <= s_tdata[2*W-1:W];
          m  <= s_tdata[2*W-1:W];
          xp <= coef_t'(1);
          xc <= coef_t'(0);
          yp <= coef_t'(0);
          yc <= coef_t'(1);
        end
      end
      ST_CHECK: begin
        if ((b == '0) && (m == '0)) inv <= '0;
      end
      ST_DIV: begin
        if (rsp.done) begin
          a  <= b;
          b  <= rsp.rem;
          xp <= xc;
          xc <= xp - rsp.prod_x;
          yp <= yc;
          yc <= yp - rsp.prod_y;
        end
      end
      ST_RDIV: begin
        if (rsp.done) begin
          inv <= (xp[W] && (rsp.rem != '0)) ? (m - rsp.rem) : rsp.rem;
        end
      end
      ST_FINISH: begin
        if (out_load) m_tdata <= OUT_W'({inv, yp, xp, a});
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/eemi_checker.sv =====
// ----------------------------------------------------------------------------
// Extended Euclid modular inverse core - port checker
// Watches the stream ports of the top level; bound to it below.
// ----------------------------------------------------------------------------
`include "extended_euclid_modular_inverse_core_defines.svh"

module eemi_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic [eemi_pkg::IN_W-1:0]  s_tdata,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [eemi_pkg::OUT_W-1:0] m_tdata
);
  import eemi_pkg::*;

  logic in_txn;
  logic pad_zero;

  assign in_txn   = s_tvalid && s_tready && (s_tdata == s_tdata);
  assign pad_zero = ((m_tdata >> (4 * W + 2)) == '0);

  `EEMI_ASSERT_NEXT_RST(a_reset_clears, rst, !m_tvalid, "output valid after reset")
  `EEMI_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled output changed")
  `EEMI_ASSERT_NEXT(a_busy_after_in, in_txn, !s_tready, "input ready right after a transaction")
  `EEMI_ASSERT_NOW(a_result_after_work, $rose(m_tvalid), $past(!s_tready) && pad_zero, "result without work or bad pad")

endmodule

bind extended_euclid_modular_inverse_core eemi_checker u_eemi_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== dv/eemi_result_checker.sv =====
// ----------------------------------------------------------------------------
// Extended Euclid modular inverse core - result checker
// Watches both stream channels. Every accepted input transaction is run through
// an extended Euclid model here, and the expected result is queued. Every
// accepted output transaction is compared field by field with the oldest
// queued expectation.
// ----------------------------------------------------------------------------
module eemi_result_checker
  import eemi_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // value, modulus
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [OUT_W-1:0] m_tdata,   // gcd, coef_value, coef_modulus, inverse
  output int               fail_count,
  output int               pending,
  output int               checked
);

  typedef struct packed {
    word_t gcd;
    coef_t coef_value;
    coef_t coef_modulus;
    word_t inverse;
  } bezout_t;

  bezout_t results_due[$];
  int      fails = 0;
  int      n_checked = 0;

  // Coefficients are carried as wrapping 64-bit two's complement values.
  function automatic bezout_t run_euclid(input word_t value, input word_t modulus);
    logic [63:0] a, b, q, r, x0, x1, y0, y1, nxt, mag, red;
    bezout_t     res;
    a  = 64'(value);
    b  = 64'(modulus);
    x0 = 64'd1;
    x1 = 64'd0;
    y0 = 64'd0;
    y1 = 64'd1;
    while (b != 64'd0) begin
      q   = a / b;
      r   = a - q * b;
      nxt = x0 - q * x1;
      x0  = x1;
      x1  = nxt;
      nxt = y0 - q * y1;
      y0  = y1;
      y1  = nxt;
      a   = b;
      b   = r;
    end
    res.gcd          = a[W-1:0];
    res.coef_value   = x0[W:0];
    res.coef_modulus = y0[W:0];
    if (modulus == '0) begin
      res.inverse = '0;
    end else if (x0[63]) begin
      mag = 64'd0 - x0;
      red = mag % 64'(modulus);
      res.inverse = (red != 64'd0) ? word_t'(64'(modulus) - red) : '0;
    end else begin
      res.inverse = word_t'(x0 % 64'(modulus));
    end
    return res;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    bezout_t want;
    bezout_t got;
    if (!rst) begin
      if (s_tvalid && s_tready)
        results_due.push_back(run_euclid(s_tdata[W-1:0], s_tdata[2*W-1:W]));
      if (m_tvalid && m_tready) begin
        got.gcd          = m_tdata[W-1:0];
        got.coef_value   = m_tdata[2*W:W];
        got.coef_modulus = m_tdata[3*W+1:2*W+1];
        got.inverse      = m_tdata[4*W+1:3*W+2];
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result transaction, expected none, actual %h",
                   $time, m_tdata);
          fails++;
        end else begin
          want = results_due.pop_front();
          check_field("gcd", 64'(want.gcd), 64'(got.gcd));
          check_field("coef_value", 64'(want.coef_value), 64'(got.coef_value));
          check_field("coef_modulus", 64'(want.coef_modulus), 64'(got.coef_modulus));
          check_field("inverse", 64'(want.inverse), 64'(got.inverse));
          n_checked++;
        end
      end
    end
    fail_count <= fails;
    pending    <= results_due.size();
    checked    <= n_checked;
  end

endmodule

// ===== dv/tb_extended_euclid_modular_inverse_core.sv =====
// ----------------------------------------------------------------------------
// Extended Euclid modular inverse core - testbench
// Sends directed operand pairs (zeros, ones, all-ones, equal operands, gcd
// above one, value above modulus, consecutive Fibonacci numbers) and then a
// random mix, in bursts with random gaps, while the result side stalls in
// changing patterns. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_extended_euclid_modular_inverse_core;
  import eemi_pkg::*;

  localparam int N_ITEMS      = 370;
  localparam int IDLE_LIMIT   = 10000;
  localparam int DRAIN_CYCLES = 2000;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_MOSTLY,
    RDY_RARELY
  } ready_mode_e;

  logic             clk      = 1'b0;
  logic             rst      = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata  = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  int fail_count;
  int pending;
  int checked;

  word_t       operand_value[$];
  word_t       operand_modulus[$];
  int          n_directed;
  int          sent;
  int          burst_len;
  int          gap_len;
  int          idle_cycles = 0;
  ready_mode_e ready_mode  = RDY_ALWAYS;
  int          mode_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  extended_euclid_modular_inverse_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  eemi_result_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  task automatic add_pair(input word_t value, input word_t modulus);
    operand_value.push_back(value);
    operand_modulus.push_back(modulus);
  endtask

  // consecutive Fibonacci numbers give the longest Euclid runs
  task automatic add_fib_pair();
    logic [63:0] a, b, t;
    a = 64'($urandom_range(1, 9));
    b = 64'($urandom_range(1, 9));
    while (a + b <= 64'hFFFF_FFFF) begin
      t = a + b;
      a = b;
      b = t;
    end
    if ($urandom_range(0, 1) != 0)
      add_pair(word_t'(a), word_t'(b));
    else
      add_pair(word_t'(b), word_t'(a));
  endtask

  function automatic word_t edge_word();
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return word_t'(1);
      default: return '1;
    endcase
  endfunction

  task automatic add_random_pair();
    int    pick;
    word_t g;
    word_t w;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      add_pair($urandom, $urandom);
    end else if (pick < 62) begin
      add_pair($urandom_range(0, 255), $urandom_range(0, 255));
    end else if (pick < 72) begin
      g = $urandom_range(2, 1000);
      add_pair(g * $urandom_range(0, 32'hFFFF_FFFF / g),
               g * $urandom_range(1, 32'hFFFF_FFFF / g));
    end else if (pick < 80) begin
      add_fib_pair();
    end else if (pick < 88) begin
      add_pair($urandom, $urandom_range(1, 16));
    end else if (pick < 94) begin
      if ($urandom_range(0, 1) != 0)
        add_pair(edge_word(), $urandom);
      else
        add_pair($urandom, edge_word());
    end else begin
      w = $urandom_range(1, 32'hFFFF);
      if ($urandom_range(0, 1) != 0)
        add_pair(w, w);
      else
        add_pair(w * $urandom_range(1, 32'hFFFF), w);
    end
  endtask

  // receiver: ready pattern switches between always, mostly and rarely ready modes at random intervals
  always @(posedge clk) begin
    if (rst) begin
      m_tready    <= 1'b0;
      ready_mode  <= RDY_ALWAYS;
      mode_cycles <= 0;
    end else begin
      if (mode_cycles == 0) begin
        ready_mode  <= ready_mode_e'($urandom_range(0, 2));
        mode_cycles <= $urandom_range(16, 300);
      end else begin
        mode_cycles <= mode_cycles - 1;
      end
      case (ready_mode)
        RDY_ALWAYS: m_tready <= 1'b1;
        RDY_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
        default:    m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, IDLE_LIMIT, pending);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    add_pair(32'd0, 32'd0);
    add_pair(32'd5, 32'd0);
    add_pair(32'd0, 32'd7);
    add_pair(32'hFFFF_FFFF, 32'd0);
    add_pair(32'd0, 32'hFFFF_FFFF);
    add_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_pair(32'd1, 32'd1);
    add_pair(32'd1, 32'hFFFF_FFFF);
    add_pair(32'hFFFF_FFFF, 32'd1);
    add_pair(32'd3, 32'd7);
    add_pair(32'd6, 32'd9);
    add_pair(32'd100, 32'd7);
    add_pair(32'd12345, 32'd12345);
    add_pair(32'd1836311903, 32'd2971215073);
    add_pair(32'd2971215073, 32'd1836311903);
    add_pair(32'h8000_0000, 32'h4000_0000);
    add_pair(32'h8000_0000, 32'h7FFF_FFFF);
    add_pair(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    add_pair(32'd1, 32'd2);
    add_pair(32'hAAAA_AAAA, 32'h5555_5555);
    add_pair(32'd17, 32'hFFFF_FFFB);
    n_directed = operand_value.size();
    while (operand_value.size() < N_ITEMS)
      add_random_pair();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    sent = 0;
    while (sent < N_ITEMS) begin
      burst_len = $urandom_range(1, 8);
      for (int k = 0; k < burst_len && sent < N_ITEMS; k++) begin
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'({operand_modulus[sent], operand_value[sent]});
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sent++;
      end
      if (sent < N_ITEMS) begin
        gap_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        if (gap_len > 0) begin
          s_tvalid <= 1'b0;
          repeat (gap_len) @(posedge clk);
        end
      end
    end
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d operand pairs (%0d directed, %0d random), checked %0d results",
             sent, n_directed, sent - n_directed, checked);
    $display("under bursty input and varying output backpressure.");
    if (fail_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
